/* src/assert_macros.svh */
// Assertion macros shared by the histogram accumulator RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that an implication holds at every clock edge outside reset.
`define HA_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a property holds at every clock edge, reset included.
`define HA_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`endif

/* src/hacc_pkg.sv */
// Package for the histogram accumulator: types, codes and constants.
// No dependencies.
`default_nettype none
package hacc_pkg;
	localparam int NUM_BINS_DEF = 4096;
	localparam int CNT_W = 32;
	localparam int IDX_W = 12;

	localparam logic [1:0] CFG_MIN = 2'd0;
	localparam logic [1:0] CFG_MAX = 2'd1;
	localparam logic [1:0] CFG_TYPE = 2'd2;

	localparam logic [3:0] ST_F32 = 4'd8;
	localparam logic [3:0] ST_F64 = 4'd9;

	localparam logic FUNC_ADD = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_DECODE, S_READ, S_WRITE, S_OUT
	} state_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic clr_we;
		logic load_in;
		logic cap_dec;
		logic mem_rd;
		logic upd;
		logic out_load;
	} cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic clr_done;
		logic is_read;
		logic ok;
	} sts_t;
endpackage
`default_nettype wire

/* src/hacc_datapath.sv */
// Datapath of the histogram accumulator: sample decode, bin store, peak.
// Depends on hacc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module hacc_datapath import hacc_pkg::*; #(
	parameter int NUM_BINS = NUM_BINS_DEF,
	localparam int AW = $clog2(NUM_BINS)
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cmd_t cmd,
	output sts_t sts,
	input  wire logic cfg_we,
	input  wire logic [1:0] cfg_idx,
	input  wire logic [31:0] cfg_data,
	input  wire logic func,
	input  wire logic [63:0] sample_bits,
	input  wire logic [11:0] read_bin,
	input  wire logic last_sample,
	output logic [11:0] bin_index,
	output logic [31:0] bin_count,
	output logic [31:0] peak_count,
	output logic out_of_range,
	output logic series_done
);
	logic signed [31:0] min_q, max_q;
	logic [3:0] type_q;
	logic func_q, last_q;
	logic [63:0] bits_q;
	logic [11:0] rbin_q;
	logic [AW:0] clr_q;
	logic [AW-1:0] addr_q;
	logic ok_q;
	logic [31:0] peak_q;
	logic [31:0] mem [NUM_BINS];
	logic [31:0] rd_q;
	logic [31:0] cnt_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '0;
			max_q <= 32'sd4095;
			type_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_MIN: min_q <= cfg_data;
				CFG_MAX: max_q <= cfg_data;
				CFG_TYPE: type_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Capture the transaction.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			func_q <= func;
			bits_q <= sample_bits;
			rbin_q <= read_bin;
			last_q <= last_sample;
		end
	end

	// Decode the sample to an integer value; flag values beyond any range.
	logic signed [35:0] val;
	logic dec_ok;
	always_comb begin
		logic [63:0] u;
		logic neg;
		logic [63:0] mag;
		logic [10:0] ex;
		logic [52:0] man;
		logic signed [12:0] e;
		logic [86:0] sh;
		logic [34:0] ip;
		logic half;
		u = bits_q;
		neg = 1'b0;
		mag = '0;
		dec_ok = 1'b0;
		ex = '0;
		man = '0;
		e = '0;
		sh = '0;
		ip = '0;
		half = 1'b0;
		val = '0;
		if (type_q <= 4'd7) begin
			case (type_q[1:0])
				2'd0: begin u = {56'd0, bits_q[7:0]}; neg = type_q[2] == 1'b0 && bits_q[7]; end
				2'd1: begin u = {48'd0, bits_q[15:0]}; neg = type_q[2] == 1'b0 && bits_q[15]; end
				2'd2: begin u = {32'd0, bits_q[31:0]}; neg = type_q[2] == 1'b0 && bits_q[31]; end
				default: begin u = bits_q; neg = type_q[2] == 1'b0 && bits_q[63]; end
			endcase
			if (neg) begin
				case (type_q[1:0])
					2'd0: mag = {56'd0, 8'(-u[7:0])};
					2'd1: mag = {48'd0, 16'(-u[15:0])};
					2'd2: mag = {32'd0, 32'(-u[31:0])};
					default: mag = -u;
				endcase
				if (mag == '0) mag = 64'h8000_0000_0000_0000;
			end else begin
				mag = u;
			end
			dec_ok = mag < 64'h2_0000_0000;
			val = neg ? -$signed({1'b0, mag[34:0]}) : $signed({1'b0, mag[34:0]});
		end else if (type_q == ST_F32 || type_q == ST_F64) begin
			if (type_q == ST_F32) begin
				neg = bits_q[31];
				ex = (bits_q[30:23] == 8'hFF) ? 11'h7FF :
					(bits_q[30:23] == 8'h00) ? 11'd0 : 11'(bits_q[30:23]) + 11'd896;
				man = {(bits_q[30:23] != 8'h00), bits_q[22:0], 29'd0};
			end else begin
				neg = bits_q[63];
				ex = bits_q[62:52];
				man = {(bits_q[62:52] != 11'd0), bits_q[51:0]};
			end
			e = $signed({2'b00, ex}) - 13'sd1023;
			// value = man * 2^(e-52); finite and |x| < 2^33 means e <= 32
			if (ex != 11'h7FF && e <= 13'sd32) begin
				if (e >= -13'sd1) begin
					sh = {34'd0, man} << (e + 13'sd1);
					ip = {1'b0, sh[86:53]};
					half = sh[52];
				end
				// round half away from zero on the magnitude
				ip = ip + {34'd0, half};
				dec_ok = 1'b1;
				val = neg ? -$signed({1'b0, ip}) : $signed({1'b0, ip});
			end
		end
	end

	// Register the decode result and the bin address.
	logic signed [36:0] diff;
	logic in_rng;
	assign diff = 37'(val) - 37'(min_q);
	assign in_rng = dec_ok && val >= 36'(min_q) && val <= 36'(max_q) &&
		diff < 37'(NUM_BINS);
	always_ff @(posedge clk) begin
		if (cmd.cap_dec) begin
			if (func_q == FUNC_READ) begin
				ok_q <= 32'(rbin_q) < NUM_BINS;
				addr_q <= AW'(rbin_q);
			end else begin
				ok_q <= in_rng;
				addr_q <= AW'(diff);
			end
		end
	end
	assign sts.ok = ok_q;
	assign sts.is_read = func_q;

	// Clearing sweep counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (cmd.clr_we && !clr_q[AW]) clr_q <= clr_q + 1'b1;
	end
	assign sts.clr_done = clr_q[AW];

	// Bin store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.clr_we) mem[clr_q[AW-1:0]] <= '0;
		else if (cmd.upd) mem[addr_q] <= cnt_q;
		if (cmd.mem_rd) rd_q <= mem[addr_q];
	end

	// Saturating increment.
	always_ff @(posedge clk) begin
		if (cmd.upd) cnt_q <= cnt_q;
		else cnt_q <= (rd_q == 32'hFFFF_FFFF) ? rd_q : rd_q + 32'd1;
	end

	// Peak tracker.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) peak_q <= '0;
		else if (cmd.upd && cnt_q > peak_q) peak_q <= cnt_q;
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			series_done <= last_q;
			out_of_range <= !ok_q;
			peak_count <= (cmd.upd && cnt_q > peak_q) ? cnt_q : peak_q;
			if (!ok_q) begin
				bin_index <= func_q ? rbin_q : '0;
				bin_count <= '0;
			end else begin
				bin_index <= 12'(addr_q);
				bin_count <= func_q ? rd_q : cnt_q;
			end
		end
	end

	`HA_ASSERT(a_peak_mono, clk, arst_n, (peak_q != $past(peak_q)) |-> (peak_q > $past(peak_q)), "peak decreased")
	`HA_ASSERT(a_clr_write, clk, arst_n, cmd.clr_we |-> !cmd.upd, "clear and update overlap")
endmodule
`default_nettype wire

/* src/hacc_ctrl.sv */
// Controller of the histogram accumulator: clear sweep and item sequencing.
// Depends on hacc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module hacc_ctrl import hacc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  wire logic out_stall,
	input  wire sts_t sts,
	output cmd_t cmd
);
	state_t state_q, state_d;
	logic ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else state_q <= state_d;
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (cmd.out_load) ov_q <= 1'b1;
		else if (!out_stall) ov_q <= 1'b0;
	end
	assign out_valid = ov_q;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = 1'b1;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_we = !sts.clr_done;
				if (sts.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				in_stall = 1'b0;
				cmd.load_in = in_valid;
				if (in_valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				cmd.cap_dec = 1'b1;
				state_d = S_READ;
			end
			S_READ: begin
				cmd.mem_rd = 1'b1;
				state_d = S_WRITE;
			end
			S_WRITE: begin
				// cnt_q takes the incremented value here
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!ov_q || !out_stall) begin
					cmd.out_load = 1'b1;
					cmd.upd = sts.ok && !sts.is_read;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	`HA_ASSERT_ALWAYS(a_no_accept_clear, clk, (state_q == S_CLEAR) |-> in_stall, "accept during clear")
	`HA_ASSERT(a_out_hold, clk, arst_n, (out_valid && out_stall) |=> out_valid, "result lost")
endmodule
`default_nettype wire

/* src/histogram_accumulator.sv */
// Histogram accumulator with peak count: each transaction either adds a
// decoded sample to its bin (saturating at 2^32-1) or reads one bin; a
// sample out of range is flagged, not counted. An item runs accept, decode,
// memory read, increment, then write-back with output, for the bin memory's
// read-modify-write, before the next is taken; a stalled result holds off
// the next input. After reset a clearing pass zeroes the store, during
// which no input is taken. Depends on hacc_pkg, hacc_ctrl and hacc_datapath.
`default_nettype none
module histogram_accumulator import hacc_pkg::*; #(
	parameter int NUM_BINS = NUM_BINS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic func,
	input  wire logic [63:0] sample_bits,
	input  wire logic [11:0] read_bin,
	input  wire logic last_sample,
	output logic out_valid,
	input  wire logic out_stall,
	output logic [11:0] bin_index,
	output logic [31:0] bin_count,
	output logic [31:0] peak_count,
	output logic out_of_range,
	output logic series_done
);
	cmd_t cmd;
	sts_t sts;

	hacc_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
	);

	hacc_datapath #(.NUM_BINS(NUM_BINS)) u_dp (
		.clk, .arst_n, .cmd, .sts, .cfg_we, .cfg_idx(cfg_index), .cfg_data,
		.func, .sample_bits, .read_bin, .last_sample, .bin_index, .bin_count,
		.peak_count, .out_of_range, .series_done
	);
endmodule
`default_nettype wire
